/* design/quaternion_vector_rotate_top_defines.svh */
// Assertion macros for the quaternion vector rotation checker.
// No dependencies; included by the checker file only.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// implication within the same cycle
`define QVR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qvr check failed");

// implication in the next cycle
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qvr check failed");

`endif

/* design/qvr_pkg.sv */
// Shared widths, register indexes and payload types of the quaternion rotator.
// No dependencies; used by every other design file but the defines header.
package qvr_pkg;

   localparam int QuatWidth   = 16;
   localparam int VecWidth    = 16;
   localparam int ProdWidth   = QuatWidth + VecWidth;
   localparam int TermWidth   = ProdWidth + 2;
   localparam int Prod2Width  = TermWidth + QuatWidth;
   localparam int AccWidth    = Prod2Width + 2;
   localparam int RoundShift  = 28;
   localparam int ShiftWidth  = AccWidth - RoundShift;
   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CsrQuatW = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrQuatX = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrQuatY = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrQuatZ = 3'd3;

   localparam logic signed [QuatWidth-1:0] QuatOne = 16'sd16384;

   localparam logic signed [AccWidth-1:0]   RoundBias = AccWidth'(64'sd134217728);
   localparam logic signed [ShiftWidth-1:0] SatMax    = ShiftWidth'(32'sd32767);
   localparam logic signed [ShiftWidth-1:0] SatMin    = ShiftWidth'(-32'sd32768);

   typedef struct packed {
      logic signed [QuatWidth-1:0] w;
      logic signed [QuatWidth-1:0] x;
      logic signed [QuatWidth-1:0] y;
      logic signed [QuatWidth-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [VecWidth-1:0] x;
      logic signed [VecWidth-1:0] y;
      logic signed [VecWidth-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [TermWidth-1:0] w;
      logic signed [TermWidth-1:0] x;
      logic signed [TermWidth-1:0] y;
      logic signed [TermWidth-1:0] z;
   } term_type;

   typedef struct packed {
      logic signed [AccWidth-1:0] x;
      logic signed [AccWidth-1:0] y;
      logic signed [AccWidth-1:0] z;
   } acc_type;

   typedef struct packed {
      logic signed [VecWidth-1:0] x;
      logic signed [VecWidth-1:0] y;
      logic signed [VecWidth-1:0] z;
      logic                       sat;
   } rot_type;

endpackage

/* design/qvr_intf.sv */
// Handshake channels of the quaternion rotator: vector input, result, register write.
// Depends on qvr_pkg for field widths.
interface qvr_req_intf;
   logic                                valid;
   logic                                ready;
   logic signed [qvr_pkg::VecWidth-1:0] vec_x;
   logic signed [qvr_pkg::VecWidth-1:0] vec_y;
   logic signed [qvr_pkg::VecWidth-1:0] vec_z;
   modport source (output valid, vec_x, vec_y, vec_z, input ready);
   modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_rsp_intf;
   logic                                valid;
   logic                                ready;
   logic signed [qvr_pkg::VecWidth-1:0] rot_x;
   logic signed [qvr_pkg::VecWidth-1:0] rot_y;
   logic signed [qvr_pkg::VecWidth-1:0] rot_z;
   logic                                saturated;
   modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
   modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

interface qvr_csr_intf;
   logic                                 valid;
   logic                                 ready;
   logic [qvr_pkg::CsrIdxWidth-1:0]      index;
   logic [qvr_pkg::QuatWidth-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/qvr_qv_mult.sv */
// Two pipeline stages forming t = q * (0, v): products, then signed sums.
// Depends on qvr_pkg.
module qvr_qv_mult (
   input  logic               clock,
   input  logic               reset,
   input  qvr_pkg::quat_type  quat,
   input  logic               in_valid,
   output logic               in_ready,
   input  qvr_pkg::vec_type   in_vec,
   output logic               out_valid,
   input  logic               out_ready,
   output qvr_pkg::term_type  out_term
);

   logic signed [qvr_pkg::ProdWidth-1:0] prod_in [12];
   logic signed [qvr_pkg::ProdWidth-1:0] prod_ff [12];
   qvr_pkg::term_type                    term_in;
   qvr_pkg::term_type                    term_ff;
   logic                                 v1_ff;
   logic                                 v2_ff;
   logic                                 s1_ready;
   logic                                 s2_ready;

   assign s2_ready  = !v2_ff || out_ready;
   assign s1_ready  = !v1_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = v2_ff;
   assign out_term  = term_ff;

   always_comb begin
      prod_in[0]  = quat.x * in_vec.x;
      prod_in[1]  = quat.y * in_vec.y;
      prod_in[2]  = quat.z * in_vec.z;
      prod_in[3]  = quat.w * in_vec.x;
      prod_in[4]  = quat.y * in_vec.z;
      prod_in[5]  = quat.z * in_vec.y;
      prod_in[6]  = quat.w * in_vec.y;
      prod_in[7]  = quat.z * in_vec.x;
      prod_in[8]  = quat.x * in_vec.z;
      prod_in[9]  = quat.w * in_vec.z;
      prod_in[10] = quat.x * in_vec.y;
      prod_in[11] = quat.y * in_vec.x;
   end

   always_comb begin
      term_in.w = -(qvr_pkg::TermWidth'(prod_ff[0]) + qvr_pkg::TermWidth'(prod_ff[1])
                    + qvr_pkg::TermWidth'(prod_ff[2]));
      term_in.x = qvr_pkg::TermWidth'(prod_ff[3]) + qvr_pkg::TermWidth'(prod_ff[4])
                  - qvr_pkg::TermWidth'(prod_ff[5]);
      term_in.y = qvr_pkg::TermWidth'(prod_ff[6]) + qvr_pkg::TermWidth'(prod_ff[7])
                  - qvr_pkg::TermWidth'(prod_ff[8]);
      term_in.z = qvr_pkg::TermWidth'(prod_ff[9]) + qvr_pkg::TermWidth'(prod_ff[10])
                  - qvr_pkg::TermWidth'(prod_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            v1_ff <= in_valid;
         end
         if (s2_ready) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (s2_ready && v1_ff) begin
         term_ff <= term_in;
      end
   end

endmodule

/* design/qvr_tc_mult.sv */
// Two pipeline stages forming the vector part of t * conj(q): products, then sums.
// Depends on qvr_pkg.
module qvr_tc_mult (
   input  logic               clock,
   input  logic               reset,
   input  qvr_pkg::quat_type  quat,
   input  logic               in_valid,
   output logic               in_ready,
   input  qvr_pkg::term_type  in_term,
   output logic               out_valid,
   input  logic               out_ready,
   output qvr_pkg::acc_type   out_acc
);

   logic signed [qvr_pkg::Prod2Width-1:0] prod_in [12];
   logic signed [qvr_pkg::Prod2Width-1:0] prod_ff [12];
   qvr_pkg::acc_type                      acc_in;
   qvr_pkg::acc_type                      acc_ff;
   logic                                  v1_ff;
   logic                                  v2_ff;
   logic                                  s1_ready;
   logic                                  s2_ready;

   assign s2_ready  = !v2_ff || out_ready;
   assign s1_ready  = !v1_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = v2_ff;
   assign out_acc   = acc_ff;

   always_comb begin
      prod_in[0]  = in_term.w * quat.x;
      prod_in[1]  = in_term.x * quat.w;
      prod_in[2]  = in_term.y * quat.z;
      prod_in[3]  = in_term.z * quat.y;
      prod_in[4]  = in_term.w * quat.y;
      prod_in[5]  = in_term.y * quat.w;
      prod_in[6]  = in_term.z * quat.x;
      prod_in[7]  = in_term.x * quat.z;
      prod_in[8]  = in_term.w * quat.z;
      prod_in[9]  = in_term.z * quat.w;
      prod_in[10] = in_term.x * quat.y;
      prod_in[11] = in_term.y * quat.x;
   end

   always_comb begin
      acc_in.x = qvr_pkg::AccWidth'(prod_ff[1]) - qvr_pkg::AccWidth'(prod_ff[0])
                 - qvr_pkg::AccWidth'(prod_ff[2]) + qvr_pkg::AccWidth'(prod_ff[3]);
      acc_in.y = qvr_pkg::AccWidth'(prod_ff[5]) - qvr_pkg::AccWidth'(prod_ff[4])
                 - qvr_pkg::AccWidth'(prod_ff[6]) + qvr_pkg::AccWidth'(prod_ff[7]);
      acc_in.z = qvr_pkg::AccWidth'(prod_ff[9]) - qvr_pkg::AccWidth'(prod_ff[8])
                 - qvr_pkg::AccWidth'(prod_ff[10]) + qvr_pkg::AccWidth'(prod_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            v1_ff <= in_valid;
         end
         if (s2_ready) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (s2_ready && v1_ff) begin
         acc_ff <= acc_in;
      end
   end

endmodule

/* design/qvr_round_sat.sv */
// Output stage: round to nearest by 2^28, saturate to 16 bits, flag clipping.
// Depends on qvr_pkg.
module qvr_round_sat (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qvr_pkg::acc_type  in_acc,
   output logic              out_valid,
   input  logic              out_ready,
   output qvr_pkg::rot_type  out_rot
);

   logic signed [qvr_pkg::AccWidth-1:0]   biased [3];
   logic signed [qvr_pkg::ShiftWidth-1:0] shifted [3];
   logic signed [qvr_pkg::VecWidth-1:0]   clipped [3];
   logic [2:0]                            clip;
   qvr_pkg::rot_type                      rot_in;
   qvr_pkg::rot_type                      rot_ff;
   logic                                  valid_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;

   always_comb begin
      biased[0] = in_acc.x + qvr_pkg::RoundBias;
      biased[1] = in_acc.y + qvr_pkg::RoundBias;
      biased[2] = in_acc.z + qvr_pkg::RoundBias;
      for (int i = 0; i < 3; i++) begin
         shifted[i] = biased[i][qvr_pkg::AccWidth-1:qvr_pkg::RoundShift];
         if (shifted[i] > qvr_pkg::SatMax) begin
            clipped[i] = qvr_pkg::SatMax[qvr_pkg::VecWidth-1:0];
            clip[i]    = 1'b1;
         end else if (shifted[i] < qvr_pkg::SatMin) begin
            clipped[i] = qvr_pkg::SatMin[qvr_pkg::VecWidth-1:0];
            clip[i]    = 1'b1;
         end else begin
            clipped[i] = shifted[i][qvr_pkg::VecWidth-1:0];
            clip[i]    = 1'b0;
         end
      end
      rot_in.x   = clipped[0];
      rot_in.y   = clipped[1];
      rot_in.z   = clipped[2];
      rot_in.sat = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rot_ff <= rot_in;
      end
   end

endmodule

/* design/quaternion_vector_rotate_top.sv */
// Quaternion vector rotation, out = q * v * conj(q), five-stage pipeline.
// Throughput one item per cycle while the result channel does not stall.
// Each stage holds under backpressure; bubbles close up ahead of a stalled result.
// Synchronous reset clears all valid bits and sets q to the identity.
// Depends on qvr_pkg, qvr_intf, qvr_qv_mult, qvr_tc_mult and qvr_round_sat.
module quaternion_vector_rotate_top (
   input  logic         clock,
   input  logic         reset,
   qvr_req_intf.sink    req_ch,
   qvr_rsp_intf.source  rsp_ch,
   qvr_csr_intf.sink    csr_ch
);

   qvr_pkg::quat_type quat_ff;
   qvr_pkg::quat_type quat_in;
   qvr_pkg::vec_type  req_vec;
   qvr_pkg::term_type term;
   qvr_pkg::acc_type  acc;
   qvr_pkg::rot_type  rot;
   logic              term_valid;
   logic              term_ready;
   logic              acc_valid;
   logic              acc_ready;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      quat_in = quat_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            qvr_pkg::CsrQuatW: quat_in.w = csr_ch.data;
            qvr_pkg::CsrQuatX: quat_in.x = csr_ch.data;
            qvr_pkg::CsrQuatY: quat_in.y = csr_ch.data;
            qvr_pkg::CsrQuatZ: quat_in.z = csr_ch.data;
            default: quat_in = quat_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.w <= qvr_pkg::QuatOne;
         quat_ff.x <= '0;
         quat_ff.y <= '0;
         quat_ff.z <= '0;
      end else begin
         quat_ff <= quat_in;
      end
   end

   assign req_vec.x = req_ch.vec_x;
   assign req_vec.y = req_ch.vec_y;
   assign req_vec.z = req_ch.vec_z;

   qvr_qv_mult u_qv_mult (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_vec    (req_vec),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_term  (term)
   );

   qvr_tc_mult u_tc_mult (
      .clock     (clock),
      .reset     (reset),
      .quat      (quat_ff),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_term   (term),
      .out_valid (acc_valid),
      .out_ready (acc_ready),
      .out_acc   (acc)
   );

   qvr_round_sat u_round_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_ready  (acc_ready),
      .in_acc    (acc),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_rot   (rot)
   );

   assign rsp_ch.rot_x     = rot.x;
   assign rsp_ch.rot_y     = rot.y;
   assign rsp_ch.rot_z     = rot.z;
   assign rsp_ch.saturated = rot.sat;

endmodule

/* design/qvr_checker.sv */
// Port-level checks of the quaternion rotator, bound to the top level.
// Depends on qvr_pkg and quaternion_vector_rotate_top_defines.svh.
`include "quaternion_vector_rotate_top_defines.svh"

module qvr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [qvr_pkg::VecWidth-1:0] req_vec_x,
   input logic signed [qvr_pkg::VecWidth-1:0] req_vec_y,
   input logic signed [qvr_pkg::VecWidth-1:0] req_vec_z,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [qvr_pkg::VecWidth-1:0] rsp_rot_x,
   input logic signed [qvr_pkg::VecWidth-1:0] rsp_rot_y,
   input logic signed [qvr_pkg::VecWidth-1:0] rsp_rot_z,
   input logic                                rsp_saturated,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   logic [2:0]                    pending_ff;
   logic [2:0]                    pending_in;
   logic                          touched_ff;
   logic                          req_take;
   logic                          rsp_take;
   logic                          rsp_stall;
   logic                          id_take;
   logic [3*qvr_pkg::VecWidth:0]  req_word;
   logic [3*qvr_pkg::VecWidth:0]  rsp_word;

   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign id_take   = req_take && pending_ff == 3'd0 && !touched_ff;
   assign req_word  = {req_vec_x, req_vec_y, req_vec_z, 1'b0};
   assign rsp_word  = {rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_saturated};

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 3'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         touched_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (csr_valid && csr_ready) begin
            touched_ff <= 1'b1;
         end
      end
   end

   `QVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))
   `QVR_ASSERT_NOW(a_no_phantom, clock, reset, rsp_valid, pending_ff != 3'd0)
   `QVR_ASSERT_NOW(a_depth, clock, reset, 1'b1, pending_ff <= 3'd5)
   `QVR_ASSERT_NOW(a_identity, clock, reset, id_take, ##5 (rsp_valid && rsp_word == $past(req_word, 5)))

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_vec_x     (req_ch.vec_x),
   .req_vec_y     (req_ch.vec_y),
   .req_vec_z     (req_ch.vec_z),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_rot_x     (rsp_ch.rot_x),
   .rsp_rot_y     (rsp_ch.rot_y),
   .rsp_rot_z     (rsp_ch.rot_z),
   .rsp_saturated (rsp_ch.saturated),
   .csr_valid     (csr_ch.valid),
   .csr_ready     (csr_ch.ready)
);
